/* rtl/csort_pkg.sv */
package csort_pkg;

   localparam int MAX_VALUE   = 16384;
   localparam int COUNT_WIDTH = 24;

   // fixed value field width of the stream payload, and a wider width for range compares
   localparam int VALUE_W = 15;
   localparam int CMP_W   = 17;

   localparam int ADDR_W  = $clog2(MAX_VALUE);
   localparam int TOTAL_W = COUNT_WIDTH + ADDR_W + 1;

   typedef logic [COUNT_WIDTH-1:0] count_type;
   typedef logic [ADDR_W-1:0]      addr_type;
   typedef logic [TOTAL_W-1:0]     total_type;
   typedef logic [VALUE_W-1:0]     value_type;

   localparam count_type COUNT_MAX = '1;
   localparam addr_type  LAST_ADDR = ADDR_W'(MAX_VALUE - 1);

   localparam logic FUNC_COUNT = 1'b0;
   localparam logic FUNC_TAKE  = 1'b1;

endpackage

/* rtl/csort_ram.sv */
module csort_ram #(
   parameter int DEPTH = 16384,
   parameter int WIDTH = 24
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/counting_sort_engine_core.sv */
// Counting sort engine: counts values 1 .. MAX_VALUE and hands them back in
// ascending order, repeats included.
// Input channel req_*: req_tuser selects the operation (count or take),
// req_tdata carries the value to count. A count transaction produces no
// output; a take transaction produces exactly one rsp_* transaction holding
// the smallest value still counted (decremented on the way out), or an empty
// flag when nothing is left, plus the sticky overflow flag.
// Sequencing: a count reads its counter, then writes it back incremented
// (unless saturated) in the counter RAM, which has one read and one write
// port. A take reads at the scan cursor, steps the cursor over each drained
// counter, writes back the decremented counter, then loads the output
// register in its emit step, which raises rsp_tvalid; an empty take goes
// straight to the emit step. A new request is taken only in the idle state.
// The next transaction is accepted while a result waits in the
// output register; if the receiver stalls with rsp_tvalid high, a further
// take holds in its emit step until the register drains.
// Reset: synchronous, active high. After reset the engine sweeps the
// MAX_VALUE (16384) counter RAM entries to zero, one entry per cycle, with
// req_tready low; overflow flag, rsp_tvalid, cursor and running total are cleared.
module counting_sort_engine_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [14:0] value, [15] zero
   input  logic [0:0]  req_tuser,   // [0] func
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [14:0] sorted_value, [15] zero
   output logic [1:0]  rsp_tuser    // [0] empty_res, [1] overflowed
);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_COUNT,
      ST_SCAN,
      ST_EMIT
   } state_type;

   state_type            state_ff,    state_in;
   csort_pkg::addr_type  clr_addr_ff, clr_addr_in;
   csort_pkg::addr_type  cursor_ff,   cursor_in;
   csort_pkg::addr_type  cnt_addr_ff, cnt_addr_in;
   csort_pkg::total_type total_ff,    total_in;
   logic                 ovf_ff,      ovf_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   csort_pkg::value_type res_value_ff, res_value_in;
   logic                 res_empty_ff, res_empty_in;
   csort_pkg::value_type rsp_value_ff;
   logic                 rsp_empty_ff;
   logic                 rsp_ovf_ff;

   // RAM access
   logic                 wr_en;
   csort_pkg::addr_type  wr_addr;
   csort_pkg::count_type wr_data;
   logic                 rd_en;
   csort_pkg::addr_type  rd_addr;
   csort_pkg::count_type rd_data;

   logic                 req_fire;
   logic                 slot_free;
   logic                 value_ok;
   logic [csort_pkg::CMP_W-1:0] value_ext;
   csort_pkg::addr_type  value_idx;

   csort_ram #(
      .DEPTH (csort_pkg::MAX_VALUE),
      .WIDTH (csort_pkg::COUNT_WIDTH)
   ) u_counts (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign slot_free  = !rsp_valid_ff || rsp_tready;

   // values outside 1 .. MAX_VALUE are dropped without touching the state
   assign value_ext = csort_pkg::CMP_W'(req_tdata[csort_pkg::VALUE_W-1:0]);
   assign value_ok  = (value_ext != '0) &&
                      (value_ext <= csort_pkg::CMP_W'(csort_pkg::MAX_VALUE));
   assign value_idx = csort_pkg::ADDR_W'(value_ext - csort_pkg::CMP_W'(1));

   always_comb begin
      state_in     = state_ff;
      clr_addr_in  = clr_addr_ff;
      cursor_in    = cursor_ff;
      cnt_addr_in  = cnt_addr_ff;
      total_in     = total_ff;
      ovf_in       = ovf_ff;
      res_value_in = res_value_ff;
      res_empty_in = res_empty_ff;
      rsp_valid_in = rsp_valid_ff;
      wr_en        = 1'b0;
      wr_addr      = cursor_ff;
      wr_data      = '0;
      rd_en        = 1'b0;
      rd_addr      = cursor_ff;

      // drop the output transaction once taken
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_CLEAR: begin
            // sweep the counter RAM to zero after reset
            wr_en       = 1'b1;
            wr_addr     = clr_addr_ff;
            clr_addr_in = clr_addr_ff + csort_pkg::ADDR_W'(1);
            if (clr_addr_ff == csort_pkg::LAST_ADDR) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               if (req_tuser[0] == csort_pkg::FUNC_COUNT) begin
                  if (value_ok) begin
                     rd_en       = 1'b1;
                     rd_addr     = value_idx;
                     cnt_addr_in = value_idx;
                     state_in    = ST_COUNT;
                  end
               end else if (total_ff == '0) begin
                  // nothing held: answer empty straight away
                  res_value_in = '0;
                  res_empty_in = 1'b1;
                  state_in     = ST_EMIT;
               end else begin
                  rd_en    = 1'b1;
                  rd_addr  = cursor_ff;
                  state_in = ST_SCAN;
               end
            end
         end
         ST_COUNT: begin
            if (rd_data == csort_pkg::COUNT_MAX) begin
               ovf_in = 1'b1;
            end else begin
               wr_en    = 1'b1;
               wr_addr  = cnt_addr_ff;
               wr_data  = rd_data + csort_pkg::COUNT_WIDTH'(1);
               total_in = total_ff + csort_pkg::TOTAL_W'(1);
               if (cnt_addr_ff < cursor_ff) begin
                  cursor_in = cnt_addr_ff;
               end
            end
            state_in = ST_IDLE;
         end
         ST_SCAN: begin
            // a nonzero total guarantees a hit at or above the cursor
            if (rd_data == '0) begin
               cursor_in = cursor_ff + csort_pkg::ADDR_W'(1);
               rd_en     = 1'b1;
               rd_addr   = cursor_ff + csort_pkg::ADDR_W'(1);
            end else begin
               wr_en        = 1'b1;
               wr_addr      = cursor_ff;
               wr_data      = rd_data - csort_pkg::COUNT_WIDTH'(1);
               total_in     = total_ff - csort_pkg::TOTAL_W'(1);
               res_value_in = csort_pkg::VALUE_W'(csort_pkg::CMP_W'(cursor_ff) +
                                                  csort_pkg::CMP_W'(1));
               res_empty_in = 1'b0;
               state_in     = ST_EMIT;
            end
         end
         ST_EMIT: begin
            // hold until the output register is free
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         cursor_ff    <= '0;
         total_ff     <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         cursor_ff    <= cursor_in;
         total_ff     <= total_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      // payload registers
      cnt_addr_ff  <= cnt_addr_in;
      res_value_ff <= res_value_in;
      res_empty_ff <= res_empty_in;
      if (state_ff == ST_EMIT && slot_free) begin
         rsp_value_ff <= res_value_ff;
         rsp_empty_ff <= res_empty_ff;
         rsp_ovf_ff   <= ovf_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_value_ff};
   assign rsp_tuser  = {rsp_ovf_ff, rsp_empty_ff};

endmodule

/* tb/counting_sort_engine_core_tb.sv */
module counting_sort_engine_core_tb;

   localparam int unsigned CYCLE_LIMIT  = 2_000_000;
   localparam int          TAIL_CYCLES  = 64;
   localparam int          RANDOM_ITEMS = 1300;
   localparam int          VALUE_TOP    = 32767;   // largest number the value field can carry

   // one transaction on the request channel
   typedef struct {
      logic                 func;
      csort_pkg::value_type value;
      bit                   hold;   // wait for every outstanding result before sending
   } sort_item_type;

   // one transaction on the response channel, laid out as the port fields
   typedef struct packed {
      logic                 overflowed;
      logic                 empty;
      csort_pkg::value_type sorted;
   } sorted_result_type;

   // response-side back-pressure patterns
   typedef enum logic [1:0] {
      RX_FREE,
      RX_COIN,
      RX_SPARSE,
      RX_HOLD
   } rx_pattern_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata  = '0;     // [14:0] value, [15] zero
   logic [0:0]  req_tuser  = '0;     // [0] func
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;           // [14:0] sorted_value, [15] zero
   logic [1:0]  rsp_tuser;           // [0] empty_res, [1] overflowed

   // shadow of the engine: counter store, cursor, values held, sticky flag
   csort_pkg::count_type tally [csort_pkg::MAX_VALUE];
   int unsigned    cursor;
   longint         held;
   logic           overflow_seen;

   sort_item_type     pending[$];
   sorted_result_type sorted_expect[$];
   sort_item_type     on_bus;
   int                burst_left = 1;
   int                gap_left   = 0;
   rx_pattern_type    rx_pattern = RX_FREE;
   int                pattern_left = 0;
   int                mismatches = 0;
   int unsigned       cycle_count = 0;

   always #2 clock = ~clock;

   counting_sort_engine_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // Apply one accepted request to the shadow state; a take books the result
   // the engine owes for it.
   function automatic void book_item(input sort_item_type it);
      int unsigned       idx;
      sorted_result_type r;
      if (it.func == csort_pkg::FUNC_COUNT) begin
         // out-of-range numbers leave everything untouched
         if (it.value == 0 || it.value > csort_pkg::MAX_VALUE)
            return;
         idx = it.value - 1;
         if (tally[idx] == csort_pkg::COUNT_MAX) begin
            // saturated: drop the count, remember the loss
            overflow_seen = 1'b1;
            return;
         end
         tally[idx] = tally[idx] + 1'b1;
         held++;
         if (idx < cursor)
            cursor = idx;
      end else begin
         if (held == 0) begin
            // nothing left: report empty and change nothing
            r.sorted = '0;
            r.empty  = 1'b1;
         end else begin
            // step over drained counters up to the smallest live one
            while (tally[cursor] == '0)
               cursor++;
            tally[cursor] = tally[cursor] - 1'b1;
            held--;
            r.sorted = csort_pkg::value_type'(cursor + 1);
            r.empty  = 1'b0;
         end
         r.overflowed = overflow_seen;
         sorted_expect.push_back(r);
      end
   endfunction

   task automatic add_item(input logic func, input csort_pkg::value_type value,
                           input bit hold);
      sort_item_type it;
      it.func  = func;
      it.value = value;
      it.hold  = hold;
      pending.push_back(it);
   endtask

   // Request driver: bursts of random length separated by random gaps.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         // book the transaction that has just gone across
         if (req_tvalid && req_tready)
            book_item(on_bus);
         if (!req_tvalid || req_tready) begin
            if (gap_left != 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (pending.size() == 0 ||
                         (pending[0].hold && sorted_expect.size() != 0)) begin
               // hold back until the response side has caught up
               req_tvalid <= 1'b0;
            end else begin
               on_bus = pending.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {1'b0, on_bus.value};
               req_tuser  <= on_bus.func;
               if (burst_left > 1) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(1, 20);
                  // a third of the bursts run straight into the next one
                  if ($urandom_range(0, 2) == 0)
                     gap_left = 0;
                  else if ($urandom_range(0, 7) == 0)
                     gap_left = $urandom_range(13, 30);
                  else
                     gap_left = $urandom_range(1, 12);
               end
            end
         end
      end
   end

   // Response monitor: compare each transaction with the oldest booked result
   // and drive tready on a back-pressure pattern of its own.
   always @(posedge clock) begin
      sorted_result_type got;
      sorted_result_type want;
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles", $time, cycle_count);
         $display("counting_sort_engine_core_tb: errors");
         $finish;
      end
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tuser[1], rsp_tuser[0], rsp_tdata[14:0]};
            if (sorted_expect.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected result, expected none, %s=%0d empty=%0b ovf=%0b",
                        $time, "actual value", got.sorted, got.empty,
                        got.overflowed);
            end else begin
               want = sorted_expect.pop_front();
               if (got !== want) begin
                  mismatches++;
                  $display("%0t: mismatch, expected value=%0d empty=%0b ovf=%0b, %s",
                           $time, want.sorted, want.empty, want.overflowed,
                           $sformatf("actual value=%0d empty=%0b ovf=%0b",
                                     got.sorted, got.empty, got.overflowed));
               end
            end
         end
         // advance the back-pressure pattern
         if (pattern_left == 0) begin
            rx_pattern   = rx_pattern_type'($urandom_range(0, 3));
            pattern_left = (rx_pattern == RX_HOLD) ? $urandom_range(1, 40)
                                                   : $urandom_range(8, 64);
         end else begin
            pattern_left--;
         end
         case (rx_pattern)
            RX_FREE:   rsp_tready <= 1'b1;
            RX_COIN:   rsp_tready <= ($urandom_range(0, 1) == 0);
            RX_SPARSE: rsp_tready <= ($urandom_range(0, 4) == 0);
            default:   rsp_tready <= 1'b0;
         endcase
      end
   end

   // Stimulus and end of run.
   initial begin
      int  random_items;
      int  stock;       // values counted and not yet taken
      int  span;
      int  n_count;
      int  n_take;
      bit  wide;
      bit  hold;

      foreach (tally[i])
         tally[i] = '0;
      cursor        = 0;
      held          = 0;
      overflow_seen = 1'b0;
      random_items  = 0;
      stock         = 0;

      // take on an empty store, then numbers the engine must ignore
      add_item(csort_pkg::FUNC_TAKE,  csort_pkg::value_type'(0), 1'b0);
      add_item(csort_pkg::FUNC_COUNT, csort_pkg::value_type'(0), 1'b0);
      add_item(csort_pkg::FUNC_COUNT,
               csort_pkg::value_type'(csort_pkg::MAX_VALUE + 1), 1'b0);
      add_item(csort_pkg::FUNC_COUNT, csort_pkg::value_type'(VALUE_TOP), 1'b0);
      add_item(csort_pkg::FUNC_COUNT, csort_pkg::value_type'(15'h5555), 1'b0);
      // both extremes, a repeat, and alternating bits
      add_item(csort_pkg::FUNC_COUNT,
               csort_pkg::value_type'(csort_pkg::MAX_VALUE), 1'b0);
      add_item(csort_pkg::FUNC_COUNT, csort_pkg::value_type'(1), 1'b0);
      add_item(csort_pkg::FUNC_COUNT, csort_pkg::value_type'(1), 1'b0);
      add_item(csort_pkg::FUNC_COUNT, csort_pkg::value_type'(15'h2AAA), 1'b0);
      // drain in ascending order; the value field of a take is junk
      add_item(csort_pkg::FUNC_TAKE,  csort_pkg::value_type'(VALUE_TOP), 1'b0);
      add_item(csort_pkg::FUNC_TAKE,  csort_pkg::value_type'(0), 1'b0);
      add_item(csort_pkg::FUNC_TAKE,  csort_pkg::value_type'(0), 1'b0);
      add_item(csort_pkg::FUNC_TAKE,  csort_pkg::value_type'(15'h5555), 1'b0);
      add_item(csort_pkg::FUNC_TAKE,  csort_pkg::value_type'(0), 1'b1);
      // counts below the cursor pull it back down
      add_item(csort_pkg::FUNC_COUNT, csort_pkg::value_type'(5), 1'b0);
      add_item(csort_pkg::FUNC_COUNT, csort_pkg::value_type'(3), 1'b0);
      add_item(csort_pkg::FUNC_TAKE,  csort_pkg::value_type'(0), 1'b0);
      add_item(csort_pkg::FUNC_COUNT, csort_pkg::value_type'(2), 1'b0);
      add_item(csort_pkg::FUNC_TAKE,  csort_pkg::value_type'(0), 1'b0);
      add_item(csort_pkg::FUNC_TAKE,  csort_pkg::value_type'(0), 1'b0);
      add_item(csort_pkg::FUNC_TAKE,  csort_pkg::value_type'(0), 1'b0);

      // Random part: count a batch, then drain it. Most batches use a narrow
      // window of numbers and mix takes in between; a few span the whole
      // range and drain completely so the long cursor scan stays rare.
      while (random_items < RANDOM_ITEMS) begin
         wide    = ($urandom_range(0, 9) == 0);
         span    = wide ? csort_pkg::MAX_VALUE : (4 << (2 * $urandom_range(0, 3)));
         n_count = $urandom_range(1, wide ? 6 : 20);
         hold    = ($urandom_range(0, 3) == 0);
         for (int i = 0; i < n_count; i++) begin
            if ($urandom_range(0, 15) == 0) begin
               // noise: a number the engine must drop
               add_item(csort_pkg::FUNC_COUNT,
                        ($urandom_range(0, 1) == 0) ? csort_pkg::value_type'(0)
                        : csort_pkg::value_type'($urandom_range(csort_pkg::MAX_VALUE + 1,
                                                                VALUE_TOP)),
                        hold);
            end else begin
               add_item(csort_pkg::FUNC_COUNT,
                        csort_pkg::value_type'($urandom_range(1, span)), hold);
               stock++;
               random_items++;
            end
            hold = 1'b0;
            if (!wide && $urandom_range(0, 3) == 0) begin
               add_item(csort_pkg::FUNC_TAKE,
                        csort_pkg::value_type'($urandom_range(0, VALUE_TOP)), 1'b0);
               if (stock > 0)
                  stock--;
               random_items++;
            end
         end
         // drain, now and then overshoot into empty takes or stop short
         n_take = stock + $urandom_range(0, 2);
         if (!wide && $urandom_range(0, 3) == 0)
            n_take = $urandom_range(0, stock);
         repeat (n_take) begin
            add_item(csort_pkg::FUNC_TAKE,
                     csort_pkg::value_type'($urandom_range(0, VALUE_TOP)), 1'b0);
            if (stock > 0)
               stock--;
            random_items++;
         end
      end

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // wait for the last request to go, then for every result
      while (pending.size() != 0 || req_tvalid)
         @(posedge clock);
      while (sorted_expect.size() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (mismatches == 0 && sorted_expect.size() == 0)
         $display("counting_sort_engine_core_tb: clean");
      else
         $display("counting_sort_engine_core_tb: errors");
      $finish;
   end

endmodule
